[rtl/h2r_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared types and constants of the HSL to RGB converter: field widths,
// hue turn scaling and the hue sector codes.
// ----------------------------------------------------------------------------
package h2r_pkg;

   // Width of every pixel field on the streams.
   localparam int FIELD_W = 16;

   // Hue is a fraction of a full turn: 2^TURN_BITS equals 360 degrees.
   localparam int TURN_BITS = 16;

   // Hue times six, before it is split into sector and position.
   localparam int POS_W = TURN_BITS + 3;

   // Packed stream payload widths (three fields, whole bytes already).
   localparam int REQ_DATA_W = 3 * FIELD_W;
   localparam int RSP_DATA_W = 3 * FIELD_W;

   // Hue sectors of 60 degrees each.
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5
   } sector_type;

endpackage

[rtl/hsl_to_rgb_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Converts one HSL pixel per beat to RGB by the hexcone construction, in a
// four-stage pipeline with one fixed-point multiplier in each of two stages.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload (lowest bits first)
//  -------  ---------  ---------------------------------------------
//  req_     in         hue_turn[15:0], saturation[31:16], luminance[47:32]
//  rsp_     out        red[15:0], green[31:16], blue[47:32]
//
//  A pixel is accepted every cycle while nothing stalls. Each result passes
//  through the four register stages in order: hue and chroma factor, chroma
//  multiply, secondary multiply, and channel sum with clamp. Each stage holds
//  its beat while the next is full, so a stall on rsp_tready fills empty
//  stages first and then backs up to req_tready. Reset is synchronous and
//  clears the stage valid bits only.
//
module hsl_to_rgb_converter
   import h2r_pkg::*;
#(
   parameter int FRAC_BITS = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request: hue_turn[15:0], saturation[31:16], luminance[47:32]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Response: red[15:0], green[31:16], blue[47:32]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Internal widths follow from the fraction width.
   localparam int TW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;   // 1 - |2L - 1|
   localparam int PW = TW + 17;                                    // t * S
   localparam int CW = TW + 18 - FRAC_BITS;                        // chroma
   localparam int WW = TURN_BITS + 1;                              // sector weight
   localparam int XW = CW + WW + 1;                                // chroma * weight
   localparam int VW = ((CW + 3) > (FRAC_BITS + 2)) ? (CW + 3) : (FRAC_BITS + 2);

   localparam logic [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;
   localparam logic [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);
   localparam logic [XW-1:0] HALF_X = XW'(1) << (TURN_BITS - 1);
   localparam logic [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;
   localparam logic [WW-1:0] TURN_W = WW'(1) << TURN_BITS;

   // Stage valid bits and the ready chain that lets bubbles collapse.
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic ready1, ready2, ready3, ready4;

   assign ready4 = !valid4_ff || rsp_tready;
   assign ready3 = !valid3_ff || ready4;
   assign ready2 = !valid2_ff || ready3;
   assign ready1 = !valid1_ff || ready2;

   assign req_tready = ready1;
   assign rsp_tvalid = valid4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         if (ready1) begin
            valid1_ff <= req_tvalid;
         end
         if (ready2) begin
            valid2_ff <= valid1_ff;
         end
         if (ready3) begin
            valid3_ff <= valid2_ff;
         end
         if (ready4) begin
            valid4_ff <= valid3_ff;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: chroma factor t = ONE - |2L - ONE|, hue sector and weight.
   // ------------------------------------------------------------------------
   logic [FIELD_W-1:0] hue_in, sat_in, lum_in;
   logic signed [TW-1:0] dist_in, dist_abs_in, t_in;
   logic [POS_W-1:0] pos_in;
   logic [TURN_BITS-1:0] frac_in;
   sector_type sector_in;
   logic [WW-1:0] weight_in;

   assign hue_in = req_tdata[FIELD_W-1:0];
   assign sat_in = req_tdata[2*FIELD_W-1:FIELD_W];
   assign lum_in = req_tdata[3*FIELD_W-1:2*FIELD_W];

   always_comb begin
      dist_in     = $signed((TW'(lum_in) << 1) - ONE_T);
      dist_abs_in = (dist_in < 0) ? -dist_in : dist_in;
      t_in        = $signed(ONE_T) - dist_abs_in;
      // Hue times six as shift and add; the top bits are the sector.
      pos_in      = (POS_W'(hue_in) << 2) + (POS_W'(hue_in) << 1);
      frac_in     = pos_in[TURN_BITS-1:0];
      sector_in   = sector_type'(pos_in[POS_W-1:TURN_BITS]);
      // Odd sectors fall from full weight, even ones rise from zero.
      weight_in   = pos_in[TURN_BITS] ? (TURN_W - WW'(frac_in)) : WW'(frac_in);
   end

   logic signed [TW-1:0] t1_ff;
   logic [FIELD_W-1:0] sat1_ff, lum1_ff;
   sector_type sector1_ff;
   logic [WW-1:0] weight1_ff;

   always_ff @(posedge clock) begin
      if (ready1) begin
         t1_ff      <= t_in;
         sat1_ff    <= sat_in;
         lum1_ff    <= lum_in;
         sector1_ff <= sector_in;
         weight1_ff <= weight_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: chroma C = round(t * S / ONE), ties toward plus infinity.
   // ------------------------------------------------------------------------
   logic signed [PW-1:0] chroma_prod_in, chroma_sum_in, chroma_shift_in;
   logic signed [CW-1:0] chroma_in;

   always_comb begin
      chroma_prod_in  = PW'(t1_ff) * PW'($signed({1'b0, sat1_ff}));
      chroma_sum_in   = chroma_prod_in + $signed(HALF_P);
      chroma_shift_in = chroma_sum_in >>> FRAC_BITS;
      chroma_in       = chroma_shift_in[CW-1:0];
   end

   logic signed [CW-1:0] chroma2_ff;
   logic [FIELD_W-1:0] lum2_ff;
   sector_type sector2_ff;
   logic [WW-1:0] weight2_ff;

   always_ff @(posedge clock) begin
      if (ready2) begin
         chroma2_ff <= chroma_in;
         lum2_ff    <= lum1_ff;
         sector2_ff <= sector1_ff;
         weight2_ff <= weight1_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: secondary term X = round(C * w / 2^16).
   // ------------------------------------------------------------------------
   logic signed [XW-1:0] x_prod_in, x_sum_in, x_shift_in;
   logic signed [CW-1:0] x_in;

   always_comb begin
      x_prod_in  = XW'(chroma2_ff) * XW'($signed({1'b0, weight2_ff}));
      x_sum_in   = x_prod_in + $signed(HALF_X);
      x_shift_in = x_sum_in >>> TURN_BITS;
      x_in       = x_shift_in[CW-1:0];
   end

   logic signed [CW-1:0] chroma3_ff, x3_ff;
   logic [FIELD_W-1:0] lum3_ff;
   sector_type sector3_ff;

   always_ff @(posedge clock) begin
      if (ready3) begin
         chroma3_ff <= chroma2_ff;
         x3_ff      <= x_in;
         lum3_ff    <= lum2_ff;
         sector3_ff <= sector2_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: place C and X by sector, add L - C/2 and clamp to [0, ONE].
   // ------------------------------------------------------------------------
   logic signed [CW-1:0] term_r, term_g, term_b;

   always_comb begin
      case (sector3_ff)
         SECTOR_RED_YELLOW: begin
            term_r = chroma3_ff; term_g = x3_ff;      term_b = '0;
         end
         SECTOR_YELLOW_GREEN: begin
            term_r = x3_ff;      term_g = chroma3_ff; term_b = '0;
         end
         SECTOR_GREEN_CYAN: begin
            term_r = '0;         term_g = chroma3_ff; term_b = x3_ff;
         end
         SECTOR_CYAN_BLUE: begin
            term_r = '0;         term_g = x3_ff;      term_b = chroma3_ff;
         end
         SECTOR_BLUE_MAGENTA: begin
            term_r = x3_ff;      term_g = '0;         term_b = chroma3_ff;
         end
         default: begin
            term_r = chroma3_ff; term_g = '0;         term_b = x3_ff;
         end
      endcase
   end

   // Rounds T + L - C/2 to nearest, then saturates to the unit range.
   function automatic logic [FIELD_W-1:0] channel_value(
      input logic signed [CW-1:0] term,
      input logic [FIELD_W-1:0]   lum,
      input logic signed [CW-1:0] chroma
   );
      logic signed [VW-1:0] sum;
      logic signed [VW-1:0] half;
      logic [VW-1:0]        clamped;
      sum  = (VW'(term) <<< 1) + $signed(VW'(lum) << 1) - VW'(chroma) + VW'(1);
      half = sum >>> 1;
      if (half < 0) begin
         clamped = '0;
      end else if (half > $signed(ONE_V)) begin
         clamped = ONE_V;
      end else begin
         clamped = half;
      end
      return clamped[FIELD_W-1:0];
   endfunction

   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign rsp_data_in = {channel_value(term_b, lum3_ff, chroma3_ff),
                         channel_value(term_g, lum3_ff, chroma3_ff),
                         channel_value(term_r, lum3_ff, chroma3_ff)};

   always_ff @(posedge clock) begin
      if (ready4) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

[rtl/h2r_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_checker
// Port-level checks of the HSL to RGB converter: reset, output hold,
// pipeline latency and the gray case.
// ----------------------------------------------------------------------------
module h2r_checker
   import h2r_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic req_beat;
   assign req_beat = req_tvalid && req_tready;

   // No result is offered straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // A result that was not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn before it was taken");

   // With the output side ready after the request beat, the pixel's result is offered.
   assert property (@(posedge clock) disable iff (reset)
      req_beat ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("result missing four cycles after the request beat");

   // Zero saturation gives the same value on all three channels.
   assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_tdata[2*FIELD_W-1:FIELD_W] == '0)
      ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      |=> (rsp_tdata[FIELD_W-1:0] == rsp_tdata[2*FIELD_W-1:FIELD_W])
          && (rsp_tdata[FIELD_W-1:0] == rsp_tdata[3*FIELD_W-1:2*FIELD_W]))
      else $error("grey pixel has unequal channels");

endmodule

bind hsl_to_rgb_converter h2r_checker u_h2r_checker (.*);
